### rtl/core/isbn_check_and_group_decode_unit_defines.svh
// Assertion macros shared by the ISBN check unit.
`ifndef ISBN_CHECK_AND_GROUP_DECODE_UNIT_DEFINES_SVH
`define ISBN_CHECK_AND_GROUP_DECODE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("icg assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ICG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("icg assertion failed");

`endif

### rtl/core/icg_pkg.sv
package icg_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_X    = 8'h58;

  // Value that an accepted X stands for.
  localparam logic [3:0] X_VALUE = 4'd10;

  typedef enum logic [2:0] {
    ST_ISBN10_OK   = 3'd0,
    ST_ISBN13_OK   = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_BAD_CHECK   = 3'd3,
    ST_X_MISPLACED = 3'd4
  } icg_status_e;

  typedef enum logic [4:0] {
    GRP_ENGLISH      = 5'd0,
    GRP_FRENCH       = 5'd1,
    GRP_GERMAN       = 5'd2,
    GRP_JAPAN        = 5'd3,
    GRP_RUSSIAN      = 5'd4,
    GRP_CHINESE      = 5'd5,
    GRP_CZECH_SLOVAK = 5'd6,
    GRP_INDIA        = 5'd7,
    GRP_NORWAY       = 5'd8,
    GRP_POLAND       = 5'd9,
    GRP_SPAIN        = 5'd10,
    GRP_BRAZIL       = 5'd11,
    GRP_SERBIA       = 5'd12,
    GRP_DENMARK      = 5'd13,
    GRP_ITALIAN      = 5'd14,
    GRP_KOREA        = 5'd15,
    GRP_DUTCH        = 5'd16,
    GRP_SWEDEN       = 5'd17,
    GRP_NGO_EU       = 5'd18,
    GRP_UNKNOWN      = 5'd19
  } icg_group_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } icg_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] group_code;
    logic [3:0] converted_check;
  } icg_out_t;

  typedef struct packed {
    logic [3:0] digit_count;
    logic [3:0] sum_mod_eleven;
    logic [3:0] sum_mod_ten;
    logic [3:0] convert_sum_mod_eleven;
    logic       x_misplaced;
    logic       x_taken;
  } icg_state_t;

  // Digits 1, 2, 4 and 5 of the ISBN.
  typedef logic [3:0][3:0] icg_lead_t;

  // Remainder by 11 for values up to 120: reciprocal multiply, then one correction.
  function automatic logic [3:0] mod_eleven(input logic [7:0] a);
    logic [15:0] p;
    logic [7:0]  r;
    p = 16'(a) * 16'd187;
    r = a - 8'({3'b000, p[15:11]} * 8'd11);
    if (r >= 8'd11) begin
      r = r - 8'd11;
    end
    return r[3:0];
  endfunction

  // Remainder by 10 for values up to 63.
  function automatic logic [3:0] mod_ten(input logic [7:0] a);
    logic [15:0] p;
    logic [7:0]  r;
    p = 16'(a) * 16'd205;
    r = a - 8'({3'b000, p[15:11]} * 8'd10);
    if (r >= 8'd10) begin
      r = r - 8'd10;
    end
    return r[3:0];
  endfunction

  function automatic icg_group_e decode_group(input logic [3:0] first,
                                              input logic [3:0] second);
    icg_group_e g;
    g = GRP_UNKNOWN;
    case (first)
      4'd0, 4'd1: g = GRP_ENGLISH;
      4'd2:       g = GRP_FRENCH;
      4'd3:       g = GRP_GERMAN;
      4'd4:       g = GRP_JAPAN;
      4'd5:       g = GRP_RUSSIAN;
      4'd7:       g = GRP_CHINESE;
      4'd8: begin
        case (second)
          4'd0:    g = GRP_CZECH_SLOVAK;
          4'd1:    g = GRP_INDIA;
          4'd2:    g = GRP_NORWAY;
          4'd3:    g = GRP_POLAND;
          4'd4:    g = GRP_SPAIN;
          4'd5:    g = GRP_BRAZIL;
          4'd6:    g = GRP_SERBIA;
          4'd7:    g = GRP_DENMARK;
          4'd8:    g = GRP_ITALIAN;
          4'd9:    g = GRP_KOREA;
          default: g = GRP_UNKNOWN;
        endcase
      end
      4'd9: begin
        case (second)
          4'd0, 4'd4: g = GRP_DUTCH;
          4'd1:       g = GRP_SWEDEN;
          4'd2:       g = GRP_NGO_EU;
          4'd3:       g = GRP_INDIA;
          default:    g = GRP_UNKNOWN;
        endcase
      end
      default: g = GRP_UNKNOWN;
    endcase
    return g;
  endfunction

endpackage

### rtl/core/isbn_check_and_group_decode_unit.sv
// ISBN checker: one character request is taken per clock cycle, with no gaps between
// characters or between ISBNs, as long as results are taken when they are offered.
// Each request passes an input register and a result register, so the result of an
// ISBN appears on the outputs once its last character has passed both, and only
// for that last character; all other characters give no result. While a result waits
// under stall, a character held in the input register cannot move on, so the input
// stalls until that result is taken. The running sums are updated by one small add and
// modular reduction per character, and the unit clears its sums after every last
// character, ready for the next ISBN.
`include "isbn_check_and_group_decode_unit_defines.svh"

module isbn_check_and_group_decode_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  icg_pkg::icg_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output icg_pkg::icg_out_t out_data_o
);

  logic                in_valid_q;
  icg_pkg::icg_in_t    in_q;
  logic                out_valid_q;
  logic                out_valid_d;
  icg_pkg::icg_out_t   out_q;
  icg_pkg::icg_state_t state_q;
  icg_pkg::icg_state_t state_next;
  icg_pkg::icg_state_t state_d;
  icg_pkg::icg_lead_t  lead_q;
  icg_pkg::icg_lead_t  lead_next;
  icg_pkg::icg_out_t   result;
  logic                advance;
  logic                fire;
  logic                in_accept;

  // The held item moves on whenever the result register is free or being emptied.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  icg_step_logic u_step (
    .state_i  (state_q),
    .lead_i   (lead_q),
    .item_i   (in_q),
    .state_o  (state_next),
    .lead_o   (lead_next),
    .result_o (result)
  );

  always_comb begin
    state_d = state_q;
    if (fire) begin
      state_d = in_q.last ? '0 : state_next;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = fire && in_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      lead_q <= lead_next;
    end
    if (fire && in_q.last) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ICG_ASSERT_SAME(a_conv_only_isbn13,
    out_valid_o && (out_data_o.status != icg_pkg::ST_ISBN13_OK),
    out_data_o.converted_check == 4'd0)
  `ICG_ASSERT_SAME(a_group_only_valid,
    out_valid_o && (out_data_o.status != icg_pkg::ST_ISBN10_OK)
      && (out_data_o.status != icg_pkg::ST_ISBN13_OK),
    out_data_o.group_code == icg_pkg::GRP_UNKNOWN)
  `ICG_ASSERT_NEXT(a_clear_after_last,
    fire && in_q.last,
    (state_q.digit_count == 4'd0) && !state_q.x_misplaced && !state_q.x_taken
      && out_valid_o)

endmodule

### rtl/core/icg_step_logic.sv
module icg_step_logic (
  input  icg_pkg::icg_state_t state_i,
  input  icg_pkg::icg_lead_t  lead_i,
  input  icg_pkg::icg_in_t    item_i,
  output icg_pkg::icg_state_t state_o,
  output icg_pkg::icg_lead_t  lead_o,
  output icg_pkg::icg_out_t   result_o
);

  logic       is_digit;
  logic       is_x;
  logic       take_x;
  logic       take;
  logic [3:0] value;
  logic [3:0] idx;
  logic [7:0] prod_eleven;
  logic [7:0] prod_ten;
  logic [7:0] prod_conv;

  assign is_digit = (item_i.char_code inside {[icg_pkg::CHAR_ZERO:icg_pkg::CHAR_NINE]});
  assign is_x     = (item_i.char_code == icg_pkg::CHAR_X);
  assign idx      = state_i.digit_count;
  // X counts only in the tenth digit position, and only once.
  assign take_x   = is_x && (idx == 4'd9) && !state_i.x_taken;
  assign take     = is_digit || take_x;
  assign value    = is_digit ? item_i.char_code[3:0] : icg_pkg::X_VALUE;

  assign prod_eleven = 8'(value) * 8'(4'd10 - idx);
  assign prod_ten    = 8'(value) * (idx[0] ? 8'd3 : 8'd1);
  assign prod_conv   = 8'(value) * 8'(4'd13 - idx);

  always_comb begin
    state_o = state_i;
    lead_o  = lead_i;
    if (take) begin
      if (state_i.x_taken) begin
        state_o.x_misplaced = 1'b1;
      end
      if (idx < 4'd10) begin
        state_o.sum_mod_eleven =
          icg_pkg::mod_eleven(8'(state_i.sum_mod_eleven) + prod_eleven);
      end
      if (idx < 4'd13) begin
        state_o.sum_mod_ten = icg_pkg::mod_ten(8'(state_i.sum_mod_ten) + prod_ten);
      end
      if (idx >= 4'd3 && idx <= 4'd11) begin
        state_o.convert_sum_mod_eleven =
          icg_pkg::mod_eleven(8'(state_i.convert_sum_mod_eleven) + prod_conv);
      end
      case (idx)
        4'd0:    lead_o[0] = value;
        4'd1:    lead_o[1] = value;
        4'd3:    lead_o[2] = value;
        4'd4:    lead_o[3] = value;
        default: lead_o = lead_i;
      endcase
      if (idx != 4'd15) begin
        state_o.digit_count = idx + 4'd1;
      end
    end
    if (take_x) begin
      state_o.x_taken = 1'b1;
    end
    if (is_x && !take_x) begin
      state_o.x_misplaced = 1'b1;
    end
  end

  always_comb begin
    result_o.status          = icg_pkg::ST_BAD_LENGTH;
    result_o.group_code      = icg_pkg::GRP_UNKNOWN;
    result_o.converted_check = 4'd0;
    if (state_o.x_misplaced) begin
      result_o.status = icg_pkg::ST_X_MISPLACED;
    end else if (state_o.digit_count == 4'd10) begin
      if (state_o.sum_mod_eleven == 4'd0) begin
        result_o.status     = icg_pkg::ST_ISBN10_OK;
        result_o.group_code = icg_pkg::decode_group(lead_o[0], lead_o[1]);
      end else begin
        result_o.status = icg_pkg::ST_BAD_CHECK;
      end
    end else if (state_o.digit_count == 4'd13) begin
      if (state_o.sum_mod_ten == 4'd0) begin
        result_o.status     = icg_pkg::ST_ISBN13_OK;
        result_o.group_code = icg_pkg::decode_group(lead_o[2], lead_o[3]);
        // A zero remainder wraps to a zero check digit, not to eleven.
        if (state_o.convert_sum_mod_eleven != 4'd0) begin
          result_o.converted_check = 4'd11 - state_o.convert_sum_mod_eleven;
        end
      end else begin
        result_o.status = icg_pkg::ST_BAD_CHECK;
      end
    end
  end

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import icg_pkg::*;

  localparam int unsigned TOTAL_ITEMS   = 1450;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  icg_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  icg_out_t out_data_o;

  isbn_check_and_group_decode_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Running ISBN state, tracked alongside the block.
  logic [3:0] dig_cnt;
  logic [3:0] chk11;
  logic [3:0] chk10;
  logic [3:0] conv11;
  logic [3:0] lead_digit [4];
  logic       x_bad;
  logic       x_used;

  icg_out_t    isbn_results_q [$];
  icg_out_t    want_res;
  logic [7:0]  isbn_chars [$];
  int unsigned fail_count = 0;
  int unsigned sent_items = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet_mode = 1'b0;
  bit          hold_request = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_isbn();
    dig_cnt = '0;
    chk11   = '0;
    chk10   = '0;
    conv11  = '0;
    x_bad   = 1'b0;
    x_used  = 1'b0;
    foreach (lead_digit[k]) lead_digit[k] = '0;
  endfunction

  function automatic icg_group_e group_of(input logic [3:0] hi, input logic [3:0] lo);
    if (hi <= 4'd1) return GRP_ENGLISH;
    if (hi <= 4'd5) return icg_group_e'(5'(hi) - 5'd1);
    if (hi == 4'd7) return GRP_CHINESE;
    if (hi == 4'd8 && lo <= 4'd9) return icg_group_e'(5'(GRP_CZECH_SLOVAK) + 5'(lo));
    if (hi == 4'd9) begin
      case (lo)
        4'd0, 4'd4: return GRP_DUTCH;
        4'd1:       return GRP_SWEDEN;
        4'd2:       return GRP_NGO_EU;
        4'd3:       return GRP_INDIA;
        default:    return GRP_UNKNOWN;
      endcase
    end
    return GRP_UNKNOWN;
  endfunction

  function automatic void absorb_digit(input int unsigned v);
    int unsigned i;
    i = 32'(dig_cnt);
    if (x_used) x_bad = 1'b1;
    if (i < 10) chk11 = 4'((chk11 + v * (10 - i)) % 11);
    if (i < 13) chk10 = 4'((chk10 + v * ((i % 2) ? 3 : 1)) % 10);
    if (i >= 3 && i <= 11) conv11 = 4'((conv11 + v * (13 - i)) % 11);
    case (i)
      0: lead_digit[0] = 4'(v);
      1: lead_digit[1] = 4'(v);
      3: lead_digit[2] = 4'(v);
      4: lead_digit[3] = 4'(v);
      default: ;
    endcase
    if (dig_cnt != 4'd15) dig_cnt = dig_cnt + 4'd1;
  endfunction

  // Folds one accepted request into the state; the final one yields the result.
  function automatic void predict_char(input icg_in_t req);
    icg_out_t res;
    if (req.char_code >= CHAR_ZERO && req.char_code <= CHAR_NINE) begin
      absorb_digit(32'(req.char_code - CHAR_ZERO));
    end else if (req.char_code == CHAR_X) begin
      if (dig_cnt == 4'd9 && !x_used) begin
        absorb_digit(32'(X_VALUE));
        x_used = 1'b1;
      end else begin
        x_bad = 1'b1;
      end
    end
    if (req.last) begin
      res.status          = ST_BAD_LENGTH;
      res.group_code      = GRP_UNKNOWN;
      res.converted_check = '0;
      if (x_bad) begin
        res.status = ST_X_MISPLACED;
      end else if (dig_cnt == 4'd10) begin
        if (chk11 == 4'd0) begin
          res.status     = ST_ISBN10_OK;
          res.group_code = group_of(lead_digit[0], lead_digit[1]);
        end else begin
          res.status = ST_BAD_CHECK;
        end
      end else if (dig_cnt == 4'd13) begin
        if (chk10 == 4'd0) begin
          res.status          = ST_ISBN13_OK;
          res.group_code      = group_of(lead_digit[2], lead_digit[3]);
          res.converted_check = (conv11 == 4'd0) ? 4'd0 : 4'd11 - conv11;
        end else begin
          res.status = ST_BAD_CHECK;
        end
      end
      isbn_results_q.push_back(res);
      clear_isbn();
    end
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] skip_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_X) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_char(input logic [7:0] code, input logic lst);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = '{char_code: code, last: lst};
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_char(in_data_i);
    sent_items++;
  endtask

  // Sends the prepared characters with optional separators; the last flag goes
  // on the final character or, with tail_sep or no characters, on a trailing separator.
  task automatic send_isbn(input int unsigned sep_pct, input bit tail_sep);
    for (int i = 0; i < isbn_chars.size(); i++) begin
      if ($urandom_range(0, 99) < sep_pct) send_char(skip_char(), 1'b0);
      send_char(isbn_chars[i], (i == isbn_chars.size() - 1) && !tail_sep);
    end
    if (tail_sep || isbn_chars.size() == 0) send_char(skip_char(), 1'b1);
  endtask

  task automatic send_text(input string text);
    isbn_chars.delete();
    foreach (text[i]) isbn_chars.push_back(text[i]);
    send_isbn(0, 1'b0);
  endtask

  task automatic build_isbn10(input int hi, input int lo, input bit good);
    int unsigned d [10];
    int unsigned total;
    isbn_chars.delete();
    total = 0;
    for (int i = 0; i < 9; i++) d[i] = $urandom_range(0, 9);
    if (hi >= 0) d[0] = hi;
    if (lo >= 0) d[1] = lo;
    for (int i = 0; i < 9; i++) total += d[i] * (10 - i);
    d[9] = (11 - total % 11) % 11;
    if (!good) d[9] = (d[9] + $urandom_range(1, 10)) % 11;
    for (int i = 0; i < 10; i++) begin
      isbn_chars.push_back((d[i] == 10) ? CHAR_X : CHAR_ZERO + 8'(d[i]));
    end
  endtask

  task automatic build_isbn13(input int hi, input int lo, input bit good);
    int unsigned d [13];
    int unsigned total;
    isbn_chars.delete();
    total = 0;
    d[0] = 9;
    d[1] = 7;
    d[2] = $urandom_range(8, 9);
    for (int i = 3; i < 12; i++) d[i] = $urandom_range(0, 9);
    if (hi >= 0) d[3] = hi;
    if (lo >= 0) d[4] = lo;
    for (int i = 0; i < 12; i++) total += d[i] * ((i % 2) ? 3 : 1);
    d[12] = (10 - total % 10) % 10;
    if (!good) d[12] = (d[12] + $urandom_range(1, 9)) % 10;
    for (int i = 0; i < 13; i++) isbn_chars.push_back(CHAR_ZERO + 8'(d[i]));
  endtask

  task automatic build_digit_run();
    int unsigned n;
    n = $urandom_range(0, 16);
    isbn_chars.delete();
    repeat (n) begin
      if ($urandom_range(0, 11) == 0) isbn_chars.push_back(CHAR_X);
      else isbn_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (isbn_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_isbn10_known();
    send_text("0-306-40615-2");
    send_text("080442957X");
    send_text("123456789X");
    send_text("0000000000");
    send_text("0306406153");
    wait_idle();
  endtask

  task automatic test_isbn13_known();
    send_text("978-0-306-40615-7");
    // The converted check digits here are X and zero.
    send_text("9780804429573");
    send_text("9780000000002");
    send_text("9780306406158");
    wait_idle();
  endtask

  task automatic test_special_cases();
    send_text("X123456789");
    send_text("123456789X5");
    send_text("123456789XX");
    send_text("978123456789X");
    send_text("03064x06152");
    send_text("0306406152-");
    send_text("-");
    send_text("0306406152030640");
    wait_idle();
  endtask

  task automatic test_all_groups();
    int unsigned n;
    n = 0;
    for (int hi = 0; hi < 10; hi++) begin
      for (int lo = 0; lo < 10; lo++) begin
        if (hi >= 8 || lo == 0) begin
          if (n % 2) build_isbn13(hi, lo, 1'b1);
          else build_isbn10(hi, lo, 1'b1);
          send_isbn(0, 1'b0);
          n++;
        end
      end
    end
    wait_idle();
  endtask

  // The receiver holds off while single-character requests keep coming, so
  // the block fills and must stall its input.
  task automatic test_fill_pressure();
    quiet_mode   = 1'b1;
    hold_request = 1'b1;
    repeat (40) send_char(8'($urandom_range(0, 255)), 1'b1);
    quiet_mode = 1'b0;
    wait_idle();
  endtask

  // Fills the run up to the total number of requests.
  task automatic test_random_stream();
    int unsigned kind;
    int unsigned sep_pct;
    while (sent_items < TOTAL_ITEMS) begin
      quiet_mode = ($urandom_range(0, 7) == 0);
      sep_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      kind       = $urandom_range(0, 99);
      if (kind < 40) begin
        build_isbn10(-1, -1, $urandom_range(0, 5) != 0);
        send_isbn(sep_pct, $urandom_range(0, 9) == 0);
      end else if (kind < 75) begin
        build_isbn13(-1, -1, $urandom_range(0, 5) != 0);
        send_isbn(sep_pct, $urandom_range(0, 9) == 0);
      end else if (kind < 88) begin
        build_digit_run();
        send_isbn(sep_pct, $urandom_range(0, 4) == 0);
      end else begin
        repeat ($urandom_range(1, 20)) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end
    quiet_mode = 1'b0;
    wait_idle();
  endtask

  // Receiver side: random stall bursts plus the long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        stall_left   = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_left != 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        if (!quiet_mode && $urandom_range(0, 5) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (isbn_results_q.size() == 0) begin
        $error("unexpected result: status %0d, group %0d, converted check %0d",
               out_data_o.status, out_data_o.group_code, out_data_o.converted_check);
        fail_count++;
      end else begin
        want_res = isbn_results_q.pop_front();
        if (out_data_o.status !== want_res.status) begin
          $error("status: expected %0d, actual %0d", want_res.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.group_code !== want_res.group_code) begin
          $error("group_code: expected %0d, actual %0d",
                 want_res.group_code, out_data_o.group_code);
          fail_count++;
        end
        if (out_data_o.converted_check !== want_res.converted_check) begin
          $error("converted_check: expected %0d, actual %0d",
                 want_res.converted_check, out_data_o.converted_check);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clear_isbn();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_isbn10_known();
    test_isbn13_known();
    test_special_cases();
    test_all_groups();
    test_fill_pressure();
    test_random_stream();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
